// ----- hw/rtl/sharpen_3x3_rgb_stream_assert.svh -----
// Assertion macros used by the port-level checker of the sharpening block.
`ifndef SHARPEN_3X3_RGB_STREAM_ASSERT_SVH
`define SHARPEN_3X3_RGB_STREAM_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SHP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/shp3_pkg.sv -----
// Types, constants and the per-channel sharpening arithmetic of the sharpening block.
package shp3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int OROW_W      = $clog2(MAX_HEIGHT);
  localparam int IROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_DATA_W  = (WID_W > HGT_W) ? WID_W : HGT_W;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ACC_W       = CH_W + 4;

  typedef logic [CH_W-1:0] chan_t;

  // Red sits in the lowest byte.
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // One column of the 3x3 window, rows from top to bottom.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Line store entry: the row above the incoming one and the row above that.
  typedef struct packed {
    pixel_t row1;
    pixel_t row2;
  } line_entry_t;

  // Which neighbours of the centre lie inside the image.
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_mask_t;

  typedef struct packed {
    logic   last;
    pixel_t pix;
  } out_item_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  // Five times the centre minus the neighbours that lie inside, clamped to a byte.
  function automatic chan_t sharpen_chan(chan_t c, chan_t u, chan_t d, chan_t l, chan_t r,
                                         nbr_mask_t m);
    logic signed [ACC_W-1:0] acc;
    chan_t                   res;
    acc = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c});
    acc = acc - $signed({4'b0000, (m.up ? u : chan_t'(0))});
    acc = acc - $signed({4'b0000, (m.dn ? d : chan_t'(0))});
    acc = acc - $signed({4'b0000, (m.lf ? l : chan_t'(0))});
    acc = acc - $signed({4'b0000, (m.rt ? r : chan_t'(0))});
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (acc > $signed(ACC_W'(255))) begin
      res = '1;
    end else begin
      res = acc[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/shp3_outq.sv -----
// Small result queue that decouples the filter pipeline from the output consumer.
module shp3_outq
  import shp3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  out_item_t             push_item,
  output logic [FIFO_CNT_W-1:0] count,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output out_item_t             pop_item
);

  out_item_t             entries_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign do_pop  = pop_valid && pop_ready;
  assign do_push = push_valid && (count_r != FIFO_CNT_W'(FIFO_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  assign count     = count_r;
  assign pop_valid = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];

endmodule

// ----- hw/rtl/shp3_kernel.sv -----
// Sharpening arithmetic over the five taps of the window, all three channels.
module shp3_kernel
  import shp3_pkg::*;
(
  input  column_t   centre_col,
  input  pixel_t    left_pix,
  input  pixel_t    right_pix,
  input  nbr_mask_t mask,
  output pixel_t    result
);

  assign result.red   = sharpen_chan(centre_col.mid.red, centre_col.top.red,
                                     centre_col.bot.red, left_pix.red, right_pix.red, mask);
  assign result.green = sharpen_chan(centre_col.mid.green, centre_col.top.green,
                                     centre_col.bot.green, left_pix.green, right_pix.green,
                                     mask);
  assign result.blue  = sharpen_chan(centre_col.mid.blue, centre_col.top.blue,
                                     centre_col.bot.blue, left_pix.blue, right_pix.blue, mask);

endmodule

// ----- hw/rtl/sharpen_3x3_rgb_stream.sv -----
// Top level of the streaming 3x3 sharpening filter for RGB pixels.
//
// Pixels enter in raster order, one per request, and each channel of the result is five
// times the centre minus its four direct neighbours, with neighbours outside the image
// counting as zero and the sum clamped to 0..255. A result leaves one row plus one pixel
// after its centre pixel entered, so after the last pixel of a frame the host sends flush
// requests (tuser high) to drain the final row plus one results; the result that closes
// the frame carries tlast, and the next pixel then starts a new frame. Flushes sent before
// a frame is complete are taken and produce nothing, and a pixel sent while a complete
// frame is still draining acts as a flush. The block takes one request per clock while
// its result queue has room: the line store is a single 2048 x 48-bit memory read and
// written back once per pixel, with the write forwarded to the next read when the width
// is one pixel, and a four-entry result queue absorbs results while the consumer stalls.
// For frames one row high, the block takes a step of its own with in_tready low before
// the first flush is taken. Writing image_width or image_height (only while the block
// is idle) abandons the frame in progress; the width is taken from cfg_wdata[11:0] only,
// a width of zero acts as one and a width above 2048 is held at 2048, and likewise for
// the height with a limit of 4096. The line store needs no clearing after reset.
module sharpen_3x3_rgb_stream
  import shp3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
  input  logic                  in_tuser,   // opcode [0]
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic                  out_tlast,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Effective frame size, already limited to the legal range when written.
  logic [WID_W-1:0]  width_r;
  logic [WID_W-1:0]  width_nxt;
  logic [HGT_W-1:0]  height_r;
  logic [HGT_W-1:0]  height_nxt;

  // Position of the next column to enter the window. The row keeps counting past the
  // bottom of the image while the frame drains, which feeds virtual pixels below it.
  logic [COL_W-1:0]  in_col_r;
  logic [COL_W-1:0]  in_col_nxt;
  logic [IROW_W-1:0] in_row_r;
  logic [IROW_W-1:0] in_row_nxt;

  // Position of the next result.
  logic [COL_W-1:0]  out_col_r;
  logic [COL_W-1:0]  out_col_nxt;
  logic [OROW_W-1:0] out_row_r;
  logic [OROW_W-1:0] out_row_nxt;

  // Issue stage decode.
  logic              draining;
  logic              primed;
  logic              auto_step;
  logic              credit_ok;
  logic              in_acc;
  logic              is_pixel;
  logic              step;
  logic              emit;
  logic              frame_end;
  logic              in_col_wrap;
  logic              out_col_wrap;
  nbr_mask_t         mask;

  // Line store: for each column, the last two rows that went past it.
  line_entry_t       lb_mem [MAX_WIDTH];
  line_entry_t       lb_q_r;

  // Window stage.
  logic              s1_valid_r;
  logic              s1_emit_r;
  logic [COL_W-1:0]  s1_addr_r;
  pixel_t            s1_pix_r;
  nbr_mask_t         s1_mask_r;
  logic              s1_last_r;
  logic              fwd_r;
  line_entry_t       fwd_data_r;
  line_entry_t       lb_entry;
  line_entry_t       lb_wdata;
  column_t           new_col;
  column_t           prev_col_r;
  pixel_t            left_r;
  pixel_t            sharp_pix;

  // Result queue.
  logic [FIFO_CNT_W-1:0] q_count;
  out_item_t             q_push_item;
  out_item_t             q_pop_item;

  // ---------------------------------------------------------------------------
  // Issue stage. Every step moves one column into the window; the step whose new
  // column lies one row plus one pixel beyond a result position produces that result.
  // ---------------------------------------------------------------------------

  // All real pixels of the frame are in once the row position reaches the height.
  assign draining = (in_row_r >= IROW_W'(height_r));

  // The window holds a complete neighbourhood once at least width + 1 columns went by.
  assign primed = (in_row_r >= IROW_W'(2)) ||
                  ((in_row_r == IROW_W'(1)) && (in_col_r != '0));

  // A frame only one row high drains before the window is full, so the block takes
  // the missing step on its own rather than on a flush.
  assign auto_step = draining && !primed;

  // Leave room in the queue for every result still in the pipeline.
  assign credit_ok = ({1'b0, q_count} + (FIFO_CNT_W + 1)'(s1_valid_r && s1_emit_r)) <
                     (FIFO_CNT_W + 1)'(FIFO_DEPTH);

  assign in_tready = credit_ok && !auto_step;
  assign in_acc    = in_tvalid && in_tready;
  assign is_pixel  = (opcode_t'(in_tuser) == OP_PIXEL);

  assign step  = auto_step || (in_acc && (draining || is_pixel));
  assign emit  = step && primed;

  assign in_col_wrap  = ({1'b0, in_col_r} + WID_W'(1)) == width_r;
  assign out_col_wrap = ({1'b0, out_col_r} + WID_W'(1)) == width_r;
  assign frame_end    = out_col_wrap &&
                        (({1'b0, out_row_r} + HGT_W'(1)) == height_r);

  assign mask.up = (out_row_r != '0);
  assign mask.dn = ({1'b0, out_row_r} + HGT_W'(1)) != height_r;
  assign mask.lf = (out_col_r != '0);
  assign mask.rt = !out_col_wrap;

  // Frame size and counters. A register write restarts the frame; so does the
  // result that closes it.
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (cfg_we) begin
      if (cfg_reg_t'(cfg_index) == CFG_WIDTH) begin
        if (cfg_wdata[WID_W-1:0] == '0) begin
          width_nxt = WID_W'(1);
        end else if (cfg_wdata[WID_W-1:0] > WID_W'(MAX_WIDTH)) begin
          width_nxt = WID_W'(MAX_WIDTH);
        end else begin
          width_nxt = cfg_wdata[WID_W-1:0];
        end
      end else begin
        if (cfg_wdata[HGT_W-1:0] == '0) begin
          height_nxt = HGT_W'(1);
        end else if (cfg_wdata[HGT_W-1:0] > HGT_W'(MAX_HEIGHT)) begin
          height_nxt = HGT_W'(MAX_HEIGHT);
        end else begin
          height_nxt = cfg_wdata[HGT_W-1:0];
        end
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (emit && frame_end) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else begin
      if (step) begin
        if (in_col_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + IROW_W'(1);
        end else begin
          in_col_nxt = in_col_r + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WID_W'(640);
      height_r   <= HGT_W'(480);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      s1_valid_r <= step;
      s1_emit_r  <= emit;
    end
  end

  // Stage payload. On a flush or an automatic step the pixel data lands in the row
  // below the image, where the bottom mask hides it.
  always_ff @(posedge clk) begin
    s1_addr_r  <= in_col_r;
    s1_pix_r   <= pixel_t'(in_tdata);
    s1_mask_r  <= mask;
    s1_last_r  <= frame_end;
    // With a one-pixel width the same entry is read again while it is being written.
    fwd_r      <= s1_valid_r && (s1_addr_r == in_col_r);
    fwd_data_r <= lb_wdata;
  end

  // ---------------------------------------------------------------------------
  // Line store, read in the issue stage and written back in the window stage.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    lb_q_r <= lb_mem[in_col_r];
    if (s1_valid_r) begin
      lb_mem[s1_addr_r] <= lb_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Window stage. The new column is two stored rows plus the incoming pixel; the
  // centre sits in the column before it and the left tap in the one before that.
  // ---------------------------------------------------------------------------
  assign lb_entry     = fwd_r ? fwd_data_r : lb_q_r;
  assign new_col.top  = lb_entry.row2;
  assign new_col.mid  = lb_entry.row1;
  assign new_col.bot  = s1_pix_r;
  assign lb_wdata.row1 = s1_pix_r;
  assign lb_wdata.row2 = lb_entry.row1;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      prev_col_r <= new_col;
      left_r     <= prev_col_r.mid;
    end
  end

  shp3_kernel u_kernel (
    .centre_col (prev_col_r),
    .left_pix   (left_r),
    .right_pix  (new_col.mid),
    .mask       (s1_mask_r),
    .result     (sharp_pix)
  );

  assign q_push_item.last = s1_last_r;
  assign q_push_item.pix  = sharp_pix;

  shp3_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s1_valid_r && s1_emit_r),
    .push_item  (q_push_item),
    .count      (q_count),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_item   (q_pop_item)
  );

  assign out_tdata = q_pop_item.pix;
  assign out_tlast = q_pop_item.last;

endmodule

// ----- hw/rtl/sharpen_3x3_rgb_stream_chk.sv -----
// Port-level checker for the sharpening block and its binding to the top level.
`include "sharpen_3x3_rgb_stream_assert.svh"

module sharpen_3x3_rgb_stream_chk
  import shp3_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [PIX_W-1:0]      in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [PIX_W-1:0]      out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_we,
  input logic                  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PEND_W = 16;

  // Requests taken minus results delivered; saturates rather than wrapping.
  logic [PEND_W-1:0] pend_r;
  logic [PEND_W-1:0] pend_nxt;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc && (pend_r != '1)) begin
      pend_nxt = pend_r + PEND_W'(1);
    end else if (out_acc && !in_acc && (pend_r != '0)) begin
      pend_nxt = pend_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SHP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed or was withdrawn")
  `SHP_ASSERT_IMP(a_no_invented, out_tvalid, pend_r != '0, "result offered without a request to cause it")
  `SHP_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result queue not empty after reset")

endmodule

bind sharpen_3x3_rgb_stream sharpen_3x3_rgb_stream_chk u_chk (.*);
